### src/ibtc_pkg.sv
// Shared constants and types for the interleaved bitplane to chunky converter.
package ibtc_pkg;

    localparam int MAX_PLANES_DEF = 4;    // default plane buffer depth
    localparam int WORD_W         = 16;   // bits in one memory word, one per pixel
    localparam int PIX_W          = 4;    // bits of one pixel index
    localparam int PIX_LAST       = 15;   // position of the last pixel of a group
    localparam int PLANES_CFG_W   = 3;
    localparam int ROW_CFG_W      = 10;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 10;
    localparam int PLANES_EFF_W   = 4;    // holds an effective plane count up to 8
    localparam int ROW_EFF_W      = 11;   // holds an effective row length up to 1024
    localparam int OUT_DATA_W     = 8;    // pixel index padded to a whole byte

    localparam logic [CFG_ADDR_W-1:0] CFG_PLANES_IN_USE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_WORDS    = 1'd1;

    localparam logic [PLANES_CFG_W-1:0] PLANES_RESET = 3'd4;
    localparam logic [ROW_CFG_W-1:0]    LINE_RESET   = 10'd80;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix t_group [WORD_W];

endpackage

### src/interleaved_bitplane_to_chunky.sv
// Interleaved bitplane words in, 16 chunky pixel indices per plane group out.
//
//  channel   dir  transaction                 payload
//  s_axis    in   one 16-bit plane word       tdata[15:0] plane_word
//  m_axis    out  one pixel of a group        tdata[3:0] pixel_index, tlast last_of_group
//  cfg       in   register write, no wait     addr 0 planes_in_use, 1 line_words
//
// Plane words are taken whenever s_axis_tready is high. A completed group is held in a
// one-group pending register and then shifted out, one pixel per cycle while m_axis_tready
// is high, so new plane words are taken while a group is still shifting out. The input
// stalls only on a word that completes a group while the pending register is still full.
// Reset (synchronous, active low) clears the counters, the flags, both valid bits and the
// registers to 4 planes and 80 words.
module interleaved_bitplane_to_chunky #(
    parameter int MAX_PLANES = ibtc_pkg::MAX_PLANES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ibtc_pkg::WORD_W-1:0]      s_axis_tdata,   // [15:0] plane_word
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ibtc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [3:0] pixel_index, [7:4] zero
    output logic                             m_axis_tlast,   // last_of_group
    input  logic                             i_cfg_we,
    input  logic [ibtc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ibtc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int WG_W  = $clog2(MAX_PLANES + 1);
    localparam int PE_W  = ibtc_pkg::PLANES_EFF_W;
    localparam int RE_W  = ibtc_pkg::ROW_EFF_W;
    localparam int CNT_W = $clog2(ibtc_pkg::PIX_LAST + 1);

    // configuration registers
    logic [ibtc_pkg::PLANES_CFG_W-1:0] r_planes_cfg;
    logic [ibtc_pkg::ROW_CFG_W-1:0]    r_line_cfg;

    // group collection state
    logic [ibtc_pkg::WORD_W-1:0] r_buf [MAX_PLANES];
    logic [WG_W-1:0]             r_wig, n_wig;
    logic [ibtc_pkg::ROW_CFG_W-1:0] r_wir, n_wir;
    logic                        r_disc, n_disc;

    // pending group and pixel shifter
    ibtc_pkg::t_group r_pend, n_pend, r_emit;
    logic             r_pend_v, n_pend_v;
    logic             r_out_v;
    logic [CNT_W-1:0] r_cnt;

    logic [PE_W-1:0] planes_eff;
    logic [RE_W-1:0] row_eff;
    logic [RE_W-1:0] remaining;
    logic [PE_W-1:0] wig_next;
    logic            start_disc;
    logic            complete;
    logic            in_fire, out_fire, emit_free, load_emit;

    // --- configuration ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes_cfg <= ibtc_pkg::PLANES_RESET;
            r_line_cfg   <= ibtc_pkg::LINE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ibtc_pkg::CFG_PLANES_IN_USE:
                    r_planes_cfg <= i_cfg_wdata[ibtc_pkg::PLANES_CFG_W-1:0];
                ibtc_pkg::CFG_LINE_WORDS:
                    r_line_cfg   <= i_cfg_wdata[ibtc_pkg::ROW_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero planes act as one; clamp the count to the buffer depth.
    // Zero row length acts as a full 1024-word row.
    always_comb begin
        planes_eff = PE_W'(r_planes_cfg);
        if (planes_eff == '0)
            planes_eff = PE_W'(1);
        if (planes_eff > PE_W'(MAX_PLANES))
            planes_eff = PE_W'(MAX_PLANES);
        row_eff = (r_line_cfg == '0) ? RE_W'(1024) : RE_W'(r_line_cfg);
    end

    // --- per-word control ---
    always_comb begin
        remaining  = (RE_W'(r_wir) < row_eff) ? row_eff - RE_W'(r_wir) : '0;
        start_disc = (r_wig == '0) && !r_disc && (remaining < RE_W'(planes_eff));
        wig_next   = PE_W'(r_wig) + PE_W'(1);
        complete   = !(r_disc || start_disc) && (wig_next >= planes_eff);
    end

    // Stall only a group-completing word while the pending group is still held.
    assign s_axis_tready = !(r_pend_v && complete);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_disc = r_disc || start_disc;
        n_wig  = r_wig;
        if (!n_disc)
            n_wig = complete ? '0 : WG_W'(wig_next);
        n_wir = r_wir + 1'b1;
        // row end: restart the row, drop any partial group
        if ((RE_W'(r_wir) + RE_W'(1)) >= row_eff) begin
            n_wir  = '0;
            n_wig  = '0;
            n_disc = 1'b0;
        end
    end

    // Build all 16 pixels from the buffered planes plus the arriving word.
    always_comb begin
        for (int p = 0; p < ibtc_pkg::WORD_W; p++) begin
            n_pend[p] = '0;
            for (int k = 0; k < MAX_PLANES; k++) begin
                if (k < ibtc_pkg::PIX_W && PE_W'(k) < planes_eff) begin
                    if (r_wig == WG_W'(k))
                        n_pend[p][k % ibtc_pkg::PIX_W] =
                            s_axis_tdata[ibtc_pkg::PIX_LAST - p];
                    else
                        n_pend[p][k % ibtc_pkg::PIX_W] =
                            r_buf[k][ibtc_pkg::PIX_LAST - p];
                end
            end
        end
    end

    // Store the word in its plane slot.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PLANES; k++) begin
            if (in_fire && !(r_disc || start_disc) && r_wig == WG_W'(k))
                r_buf[k] <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wig  <= '0;
            r_wir  <= '0;
            r_disc <= 1'b0;
        end else if (in_fire) begin
            r_wig  <= n_wig;
            r_wir  <= n_wir;
            r_disc <= n_disc;
        end
    end

    // --- pending group and pixel shifter ---
    assign out_fire  = r_out_v && m_axis_tready;
    assign emit_free = !r_out_v || (out_fire && r_cnt == CNT_W'(ibtc_pkg::PIX_LAST));
    assign load_emit = emit_free && r_pend_v;
    assign n_pend_v  = (r_pend_v && !load_emit) || (in_fire && complete);

    always_ff @(posedge i_clk) begin
        if (in_fire && complete)
            r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_pend_v <= n_pend_v;
            if (load_emit) begin
                r_out_v <= 1'b1;
                r_cnt   <= '0;
            end else if (emit_free) begin
                r_out_v <= 1'b0;
            end else if (out_fire) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Advance the shifter: pixel 0 sits at the head.
    always_ff @(posedge i_clk) begin
        if (load_emit) begin
            r_emit <= r_pend;
        end else if (out_fire) begin
            for (int p = 0; p < ibtc_pkg::PIX_LAST; p++)
                r_emit[p] <= r_emit[p + 1];
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = ibtc_pkg::OUT_DATA_W'(r_emit[0]);
    assign m_axis_tlast  = (r_cnt == CNT_W'(ibtc_pkg::PIX_LAST));

    // --- assertions ---
    a_no_pend_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && complete) |-> !r_pend_v)
        else $error("pending group overwritten");

    a_disc_at_group_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disc |-> (r_wig == '0))
        else $error("discarding inside a group");

    a_wig_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wig < WG_W'(MAX_PLANES)))
        else $error("group word count beyond buffer");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && m_axis_tlast && !r_pend_v) |=> !m_axis_tvalid)
        else $error("output valid without a group");

endmodule

### tb/tb_interleaved_bitplane_to_chunky.sv
// Self-checking testbench for the interleaved bitplane to chunky pixel converter.
module tb_interleaved_bitplane_to_chunky;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;     // pending group plus a full 16-pixel shift-out
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 24;
    localparam int WRAP_WORDS    = 20;     // short run inside a 1024-word row
    localparam int REPORT_MAX    = 10;

    // Directed opening groups at the reset setting (4 planes): all-ones, all-zeros,
    // then one group whose planes differ so bit order and plane order both show.
    localparam logic [ibtc_pkg::WORD_W-1:0] OPENING_WORDS [12] = '{
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h8000, 16'h0001, 16'hAAAA, 16'h5555
    };

    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH
    } t_flow;

    typedef struct packed {
        logic [ibtc_pkg::PIX_W-1:0] pix;
        logic                       last;
    } t_pixel;

    // Predicts the pixel stream from accepted plane words and checks the DUT output
    // against it in order.
    class chunky_scoreboard;
        logic [ibtc_pkg::PLANES_CFG_W-1:0] planes_reg;
        logic [ibtc_pkg::ROW_CFG_W-1:0]    line_reg;
        logic [ibtc_pkg::WORD_W-1:0]       plane_buf [ibtc_pkg::MAX_PLANES_DEF];
        int unsigned             group_cnt;
        int unsigned             row_cnt;
        bit                      dropping;
        t_pixel                  expected_pixels [$];
        int                      faults;
        int                      words_seen;
        int                      words_dropped;
        int                      groups_built;
        int                      pixels_checked;
        int                      reg_writes;

        function new();
            planes_reg = ibtc_pkg::PLANES_RESET;
            line_reg   = ibtc_pkg::LINE_RESET;
            foreach (plane_buf[i]) plane_buf[i] = '0;
            group_cnt      = 0;
            row_cnt        = 0;
            dropping       = 1'b0;
            faults         = 0;
            words_seen     = 0;
            words_dropped  = 0;
            groups_built   = 0;
            pixels_checked = 0;
            reg_writes     = 0;
        endfunction

        function void write_reg(input logic [ibtc_pkg::CFG_ADDR_W-1:0] addr,
                                input logic [ibtc_pkg::CFG_DATA_W-1:0] data);
            if (addr == ibtc_pkg::CFG_PLANES_IN_USE) begin
                planes_reg = data[ibtc_pkg::PLANES_CFG_W-1:0];
            end else begin
                line_reg = data[ibtc_pkg::ROW_CFG_W-1:0];
            end
            reg_writes++;
        endfunction

        function void note_word(input logic [ibtc_pkg::WORD_W-1:0] w);
            int unsigned planes_eff;
            int unsigned row_eff;
            int unsigned left_in_row;
            t_pixel      px;
            // Plane count 0 acts as 1, above the buffer depth it saturates;
            // a zero row length is the 10-bit counter's full wrap.
            planes_eff = (planes_reg == 0) ? 1 : int'(planes_reg);
            if (planes_eff > ibtc_pkg::MAX_PLANES_DEF) planes_eff = ibtc_pkg::MAX_PLANES_DEF;
            row_eff = (line_reg == 0) ? 1024 : int'(line_reg);
            words_seen++;
            // At a group start, too few words left in the row: drop the rest of it.
            if (group_cnt == 0 && !dropping) begin
                left_in_row = (row_cnt < row_eff) ? row_eff - row_cnt : 0;
                if (left_in_row < planes_eff) dropping = 1'b1;
            end
            if (dropping) begin
                words_dropped++;
            end else begin
                if (group_cnt < ibtc_pkg::MAX_PLANES_DEF) plane_buf[group_cnt] = w;
                group_cnt++;
                if (group_cnt >= planes_eff) begin
                    // Leftmost pixel first: pixel p takes bit 15-p of every plane.
                    for (int p = 0; p <= ibtc_pkg::PIX_LAST; p++) begin
                        px.pix = '0;
                        for (int k = 0; k < planes_eff; k++) begin
                            px.pix[k] = plane_buf[k][ibtc_pkg::PIX_LAST-p];
                        end
                        px.last = (p == ibtc_pkg::PIX_LAST);
                        expected_pixels.push_back(px);
                    end
                    groups_built++;
                    group_cnt = 0;
                end
            end
            row_cnt++;
            // Row end also throws away any partial group.
            if (row_cnt >= row_eff) begin
                row_cnt   = 0;
                group_cnt = 0;
                dropping  = 1'b0;
            end
        endfunction

        function void check_pixel(input logic [ibtc_pkg::PIX_W-1:0] pix, input logic last);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("%0t: unexpected pixel: index %h last %b", $realtime, pix, last);
                return;
            end
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (want.pix !== pix || want.last !== last) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("%0t: pixel %0d mismatch: expected index %h last %b, got %h %b",
                             $realtime, pixels_checked, want.pix, want.last, pix, last);
            end
        endfunction
    endclass

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [ibtc_pkg::WORD_W-1:0]         s_axis_tdata  = '0;     // [15:0] plane_word
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [ibtc_pkg::OUT_DATA_W-1:0]     m_axis_tdata;   // [3:0] pixel_index, [7:4] zero
    logic                                m_axis_tlast;   // last_of_group
    logic                                i_cfg_we      = 1'b0;
    logic [ibtc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr    = '0;
    logic [ibtc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata   = '0;

    chunky_scoreboard sb;
    int               sender_idle_pct = 0;
    int               recv_stall_pct  = 0;
    int               cycle_count     = 0;

    interleaved_bitplane_to_chunky dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: drop tready at random according to the current stall rate.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Output monitor: every pixel transaction goes to the scoreboard. Values read here
    // are the pre-edge ones, so the check does not race the DUT's own updates.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata[ibtc_pkg::PIX_W-1:0], m_axis_tlast);
    end

    // Watchdog: a hung handshake or a lost pixel ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still owed",
                     cycle_count, sb.expected_pixels.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic apply_flow(input t_flow flow);
        case (flow)
            FLOW_FREE: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
            FLOW_SENDER_IDLE: begin
                sender_idle_pct = 84;
                recv_stall_pct  = 0;
            end
            FLOW_RECEIVER_STALL: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 84;
            end
            default: begin
                sender_idle_pct = 34;
                recv_stall_pct  = 34;
            end
        endcase
    endtask

    // Offer one plane word and hold it until the transaction completes. tvalid is
    // either kept high into the next word or lowered for idle cycles, never both
    // in one step.
    task automatic send_word(input logic [ibtc_pkg::WORD_W-1:0] w);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(w);
    endtask

    // Stop sending, wait for every predicted pixel, then let the DUT settle so a
    // word that produced nothing has surely been absorbed.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write either or both registers; call only while the DUT is drained.
    task automatic write_regs(input bit set_planes,
                              input logic [ibtc_pkg::PLANES_CFG_W-1:0] planes,
                              input bit set_line,
                              input logic [ibtc_pkg::ROW_CFG_W-1:0] line);
        if (set_planes) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= ibtc_pkg::CFG_PLANES_IN_USE;
            i_cfg_wdata <= ibtc_pkg::CFG_DATA_W'(planes);
            @(posedge i_clk);
            sb.write_reg(ibtc_pkg::CFG_PLANES_IN_USE, ibtc_pkg::CFG_DATA_W'(planes));
        end
        if (set_line) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= ibtc_pkg::CFG_LINE_WORDS;
            i_cfg_wdata <= ibtc_pkg::CFG_DATA_W'(line);
            @(posedge i_clk);
            sb.write_reg(ibtc_pkg::CFG_LINE_WORDS, ibtc_pkg::CFG_DATA_W'(line));
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [ibtc_pkg::PLANES_CFG_W-1:0] planes;
        logic [ibtc_pkg::ROW_CFG_W-1:0]    line;
        logic [ibtc_pkg::WORD_W-1:0]       w;
        bit                                set_planes;
        bit                                set_line;

        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, mild flow control on both sides.
        apply_flow(FLOW_BOTH);
        // Reset setting: full-scale words, then bit order and plane order.
        foreach (OPENING_WORDS[i]) send_word(OPENING_WORDS[i]);
        wait_drained();
        // Plane count zero behaves as one plane: every word is a group.
        write_regs(1'b1, 3'd0, 1'b0, '0);
        send_word(16'h1234);
        send_word(16'h8001);
        wait_drained();
        // Plane count above the buffer depth saturates at four.
        write_regs(1'b1, 3'd7, 1'b0, '0);
        send_word(16'hC3A5);
        send_word(16'h0F0F);
        send_word(16'h00FF);
        send_word(16'hFFFF);
        // Lower the plane count with three words collected: the next word closes
        // the group at once, using only the two lowest planes.
        send_word(16'h1111);
        send_word(16'h2222);
        send_word(16'h4444);
        wait_drained();
        write_regs(1'b1, 3'd2, 1'b0, '0);
        send_word(16'h8888);
        wait_drained();
        // Row length cut below the current word count: the word is dropped and
        // the row restarts behind it.
        write_regs(1'b0, '0, 1'b1, 10'd5);
        send_word(16'hDEAD);
        wait_drained();
        // Row ending inside a group: two words in, shorten the row to three, and
        // the partial group goes away without pixels.
        write_regs(1'b1, 3'd4, 1'b1, 10'd5);
        send_word(16'hBEEF);
        send_word(16'h7E57);
        wait_drained();
        write_regs(1'b0, '0, 1'b1, 10'd3);
        send_word(16'h0420);
        wait_drained();

        // Zero row length is a 1024-word row: with three planes a short run at full
        // speed sees no row end, so no word is dropped.
        apply_flow(FLOW_FREE);
        write_regs(1'b1, 3'd3, 1'b1, 10'd0);
        repeat (WRAP_WORDS) send_word(ibtc_pkg::WORD_W'($urandom_range(0, 65535)));
        wait_drained();

        // Random phases: the first two pin the extremes, the rest draw settings,
        // sometimes touching only one register so mid-row changes occur too.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                planes = 3'd4;  line = 10'd1023;
                set_planes = 1'b1;  set_line = 1'b1;
            end else if (ph == 1) begin
                planes = 3'd1;  line = 10'd1;
                set_planes = 1'b1;  set_line = 1'b1;
            end else begin
                planes = ibtc_pkg::PLANES_CFG_W'($urandom_range(0, 7));
                if ($urandom_range(0, 3) != 0)
                    line = ibtc_pkg::ROW_CFG_W'($urandom_range(1, 12));
                else
                    line = ibtc_pkg::ROW_CFG_W'($urandom_range(13, 1023));
                set_planes = ($urandom_range(0, 3) != 0);
                set_line   = !set_planes || ($urandom_range(0, 1) == 1);
            end
            write_regs(set_planes, planes, set_line, line);
            apply_flow(t_flow'(ph % 4));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Now and then hold off until the output side has caught up.
                if ($urandom_range(0, 31) == 0) wait_drained();
                w = ($urandom_range(0, 7) == 0)
                    ? (($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000)
                    : ibtc_pkg::WORD_W'($urandom_range(0, 65535));
                send_word(w);
            end
            wait_drained();
        end

        $display("covered %0d plane words (%0d dropped at row ends), %0d groups, %0d pixels",
                 sb.words_seen, sb.words_dropped, sb.groups_built, sb.pixels_checked);
        $display("%0d register writes over plane counts 0..7 and rows 1..1024, %0d mismatches",
                 sb.reg_writes, sb.faults);
        if (sb.faults == 0 && sb.expected_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### interleaved_bitplane_to_chunky.f
src/ibtc_pkg.sv
src/interleaved_bitplane_to_chunky.sv
tb/tb_interleaved_bitplane_to_chunky.sv
